// ----- hw/rtl/admission_with_priority_waitlist_defines.svh -----
// Assertion macros for the admission controller with priority waiting list.
// Used by the top level only; no other dependencies.
`ifndef ADMISSION_WITH_PRIORITY_WAITLIST_DEFINES_SVH
`define ADMISSION_WITH_PRIORITY_WAITLIST_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define AWQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("awq assertion failed");
// Next-cycle implication, disabled during reset.
`define AWQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("awq assertion failed");
`else
`define AWQ_ASSERT_NOW(label, clk, rst, ante, cons)
`define AWQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/awq_pkg.sv -----
// Shared types and codes for the admission controller with priority waiting list.
// No dependencies.
package awq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int PRIO_W  = 8;
   localparam int ID_W    = 16;
   localparam int OCC_W   = 8;
   localparam int KIND_W  = 3;
   localparam int WCNT_W  = 7;
   localparam int OP_W    = 2;

   // request opcodes
   localparam logic [OP_W-1:0] OP_ARRIVE = 2'd0;
   localparam logic [OP_W-1:0] OP_DEPART = 2'd1;
   localparam logic [OP_W-1:0] OP_LIST   = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ADMITTED  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_QUEUED    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DROPPED   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LEFT      = 3'd3;
   localparam logic [KIND_W-1:0] KIND_PROMOTED  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_LISTED    = 3'd5;
   localparam logic [KIND_W-1:0] KIND_EMPTY     = 3'd6;
   localparam logic [KIND_W-1:0] KIND_BAD_LEAVE = 3'd7;

   // cell chain commands
   typedef logic [1:0] awq_cell_op_type;
   localparam awq_cell_op_type CELL_HOLD   = 2'd0;
   localparam awq_cell_op_type CELL_INSERT = 2'd1;
   localparam awq_cell_op_type CELL_POP    = 2'd2;
   localparam awq_cell_op_type CELL_ROTATE = 2'd3;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [ID_W-1:0]   id;
   } awq_entry_type;

   typedef struct packed {
      awq_cell_op_type op;
      awq_entry_type   new_entry;
   } awq_ctl_type;

endpackage

// ----- hw/rtl/admission_with_priority_waitlist.sv -----
// Admission controller with a stable priority waiting list.
// Depends on awq_pkg, awq_chain (awq_cell) and the defines header.
//
// Usage:
//  - req channel carries one request: arrival, departure or list readout.
//    Opcode 3 is accepted and produces nothing.
//  - rsp channel returns one or more results per request; rsp_tlast marks the
//    final result of a request. rsp_tuser carries the result kind.
//  - csr_wr_en/csr_wr_data set the occupancy limit; write only while idle.
//  - Arrivals, plain departures and empty readouts: one result, registered,
//    visible the cycle after the request is taken; a new request can be taken
//    every cycle while the receiver keeps up.
//  - A departure that promotes the list head gives two results. A readout of
//    N entries gives N results, one per cycle while the receiver keeps up, as
//    the cell chain rotates one place per result; after N results it is back in
//    order. Results leave one per cycle, while the receiver keeps up, through
//    the single output register.
//  - Sorted insert: every cell compares its priority with the new one in the
//    same cycle and shifts right or holds.
//  - Reset clears occupancy, entry count, limit (to 8) and the output valid.
//    List storage is not cleared; only slots below the count are read.
//  - If the receiver stalls, the result holds in the output register and no
//    new request is taken until it moves.
module admission_with_priority_waitlist import awq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // opcode[1:0], priority_req[9:2], identifier[25:10]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // result_id[15:0], result_priority[23:16],
                                    // occupancy_now[31:24], waiting_count[38:32]
   output logic [2:0]  rsp_tuser,   // kind[2:0]
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data  // max_occupancy
);

`include "admission_with_priority_waitlist_defines.svh"

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PROMO = 2'd1;
   localparam logic [1:0] ST_LIST  = 2'd2;

   // request fields
   logic [OP_W-1:0]   req_op;
   awq_entry_type     req_entry;
   assign req_op         = req_tdata[1:0];
   assign req_entry.prio = req_tdata[9:2];
   assign req_entry.id   = req_tdata[25:10];

   // state
   logic [OCC_W-1:0]  max_occ_ff;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;   // listed results still to send
   awq_entry_type     pend_ff, pend_in;       // head awaiting promotion report

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   awq_entry_type     rsp_entry_ff, rsp_entry_in;
   logic [OCC_W-1:0]  rsp_occ_ff;
   logic [CNT_W-1:0]  rsp_cnt_ff;
   logic              rsp_last_ff, rsp_last_in;
   logic              load;

   awq_ctl_type       ctl;
   awq_entry_type     head;

   logic              out_free;
   logic              take_in;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign take_in    = req_tvalid && req_tready;

   awq_chain #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .CNT_W       (CNT_W)
   ) u_chain (
      .clock (clock),
      .ctl   (ctl),
      .count (count_ff),
      .head  (head)
   );

   always_comb begin
      occ_in        = occ_ff;
      count_in      = count_ff;
      state_in      = state_ff;
      remain_in     = remain_ff;
      pend_in       = pend_ff;
      load          = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_last_in   = 1'b1;
      ctl.op        = CELL_HOLD;
      ctl.new_entry = req_entry;

      priority case (1'b1)
         take_in: begin
            unique case (req_op)
               OP_ARRIVE: begin
                  load         = 1'b1;
                  rsp_entry_in = req_entry;
                  if (occ_ff < max_occ_ff) begin
                     occ_in      = occ_ff + 1'b1;
                     rsp_kind_in = KIND_ADMITTED;
                  end else if (count_ff < CNT_W'(QUEUE_DEPTH)) begin
                     ctl.op      = CELL_INSERT;
                     count_in    = count_ff + 1'b1;
                     rsp_kind_in = KIND_QUEUED;
                  end else begin
                     rsp_kind_in = KIND_DROPPED;
                  end
               end
               OP_DEPART: begin
                  load         = 1'b1;
                  rsp_entry_in = '0;
                  if (occ_ff == '0) begin
                     rsp_kind_in = KIND_BAD_LEAVE;
                  end else if ((occ_ff == max_occ_ff) && (count_ff != '0)) begin
                     // freed place goes straight to the list head
                     rsp_kind_in = KIND_LEFT;
                     rsp_last_in = 1'b0;
                     ctl.op      = CELL_POP;
                     count_in    = count_ff - 1'b1;
                     pend_in     = head;
                     state_in    = ST_PROMO;
                  end else begin
                     rsp_kind_in = KIND_LEFT;
                     occ_in      = occ_ff - 1'b1;
                  end
               end
               OP_LIST: begin
                  load = 1'b1;
                  if (count_ff == '0) begin
                     rsp_kind_in  = KIND_EMPTY;
                     rsp_entry_in = '0;
                  end else begin
                     rsp_kind_in  = KIND_LISTED;
                     rsp_entry_in = head;
                     ctl.op       = CELL_ROTATE;
                     remain_in    = count_ff - 1'b1;
                     rsp_last_in  = (count_ff == CNT_W'(1));
                     state_in     = (count_ff == CNT_W'(1)) ? ST_IDLE : ST_LIST;
                  end
               end
               OP_NONE: begin
               end
            endcase
         end
         (state_ff == ST_PROMO) && out_free: begin
            load         = 1'b1;
            rsp_kind_in  = KIND_PROMOTED;
            rsp_entry_in = pend_ff;
            state_in     = ST_IDLE;
         end
         (state_ff == ST_LIST) && out_free: begin
            load         = 1'b1;
            rsp_kind_in  = KIND_LISTED;
            rsp_entry_in = head;
            ctl.op       = CELL_ROTATE;
            remain_in    = remain_ff - 1'b1;
            rsp_last_in  = (remain_ff == CNT_W'(1));
            state_in     = (remain_ff == CNT_W'(1)) ? ST_IDLE : ST_LIST;
         end
         default: begin
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         max_occ_ff   <= OCC_W'(8);
         occ_ff       <= '0;
         count_ff     <= '0;
         state_ff     <= ST_IDLE;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_occ_ff <= csr_wr_data;
         end
         occ_ff       <= occ_in;
         count_ff     <= count_in;
         state_ff     <= state_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload; occupancy and count shown are the values after the whole request
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (load) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_entry_ff <= rsp_entry_in;
         rsp_occ_ff   <= occ_in;
         rsp_cnt_ff   <= count_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {1'b0, WCNT_W'(rsp_cnt_ff), rsp_occ_ff,
                        rsp_entry_ff.prio, rsp_entry_ff.id};

   // assertions
   `AWQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH))
   `AWQ_ASSERT_NOW(a_busy_has_rsp, clock, reset, state_ff != ST_IDLE, rsp_valid_ff)
   `AWQ_ASSERT_NOW(a_list_remain, clock, reset, state_ff == ST_LIST,
                   (remain_ff != '0) && (remain_ff < count_ff))
   `AWQ_ASSERT_NEXT(a_promo_first_left, clock, reset,
                    take_in && (state_in == ST_PROMO),
                    rsp_valid_ff && (rsp_kind_ff == KIND_LEFT) && !rsp_last_ff)

endmodule

// ----- hw/rtl/awq_cell.sv -----
// One slot of the sorted waiting list: holds an entry, shifts with its neighbors.
// Depends on awq_pkg.
module awq_cell import awq_pkg::*; (
   input  logic          clock,
   input  awq_ctl_type   ctl,
   input  logic          occupied,     // slot index below the entry count
   input  logic          tail,         // last occupied slot
   input  awq_entry_type left_entry,
   input  logic          left_ge,
   input  awq_entry_type right_entry,
   input  awq_entry_type head_entry,
   output awq_entry_type entry,
   output logic          ge
);

   awq_entry_type entry_ff, entry_in;

   // new entry lands at or before this slot (strictly lower priority value wins)
   assign ge    = !occupied || (entry_ff.prio > ctl.new_entry.prio);
   assign entry = entry_ff;

   always_comb begin
      unique case (ctl.op)
         CELL_HOLD:   entry_in = entry_ff;
         CELL_INSERT: begin
            if (ge) begin
               entry_in = left_ge ? left_entry : ctl.new_entry;
            end else begin
               entry_in = entry_ff;
            end
         end
         CELL_POP:    entry_in = right_entry;
         CELL_ROTATE: entry_in = tail ? head_entry : right_entry;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- hw/rtl/awq_chain.sv -----
// Row of waiting-list cells, head at index 0.
// Depends on awq_pkg and awq_cell.
module awq_chain import awq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic             clock,
   input  awq_ctl_type      ctl,
   input  logic [CNT_W-1:0] count,
   output awq_entry_type    head
);

   awq_entry_type entries [QUEUE_DEPTH];
   logic          ge_vec  [QUEUE_DEPTH];

   assign head = entries[0];

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      awq_entry_type left_e, right_e;
      logic          left_g;
      logic          occ, is_tail;

      assign occ     = CNT_W'(i) < count;
      assign is_tail = (CNT_W'(i + 1) == count);

      if (i == 0) begin : g_first
         assign left_e = '0;
         assign left_g = 1'b0;
      end else begin : g_mid
         assign left_e = entries[i-1];
         assign left_g = ge_vec[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_inner
         assign right_e = entries[i+1];
      end

      awq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (occ),
         .tail        (is_tail),
         .left_entry  (left_e),
         .left_ge     (left_g),
         .right_entry (right_e),
         .head_entry  (entries[0]),
         .entry       (entries[i]),
         .ge          (ge_vec[i])
      );
   end

endmodule

// ----- bench/tb_admission_with_priority_waitlist.sv -----
// Self-checking bench for the admission controller with priority waiting list.
// Needs awq_pkg and the admission_with_priority_waitlist RTL; nothing else.
module tb_admission_with_priority_waitlist;
   import awq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH      = QUEUE_DEPTH_DEF;
   // A readout of a full list is the longest a request can keep the block busy.
   localparam int SETTLE_CYCLES   = 2 * LIST_DEPTH + 8;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int CYCLE_LIMIT     = 200000;

   // One result as it leaves the block.
   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   rid;
      logic [PRIO_W-1:0] rprio;
      logic [OCC_W-1:0]  occ;
      logic [WCNT_W-1:0] wcnt;
      logic              last;
   } admission_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // opcode[1:0], priority_req[9:2], identifier[25:10]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // result_id[15:0], result_priority[23:16],
                              // occupancy_now[31:24], waiting_count[38:32]
   logic [2:0]  rsp_tuser;    // kind[2:0]
   logic        rsp_tlast;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;  // max_occupancy

   // Shadow state of the controller: limit, occupancy and the sorted list.
   int unsigned   limit_shadow;
   int unsigned   occupancy_shadow;
   int unsigned   waitlist_count;
   awq_entry_type waitlist_shadow [LIST_DEPTH];

   // Results predicted for accepted requests, oldest first.
   admission_result_type expected_results[$];

   int mismatch_count;
   int req_gap_pct;        // chance per cycle that the sender idles
   int rsp_stall_pct;      // chance per cycle that the receiver stalls
   int hold_off_requests;  // bumped to ask the receiver for one long hold-off
   int cycle_count;

   admission_with_priority_waitlist #(
      .QUEUE_DEPTH(LIST_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------
   function automatic admission_result_type make_result(input logic [KIND_W-1:0] kind,
                                                        input logic [ID_W-1:0] rid,
                                                        input logic [PRIO_W-1:0] rprio);
      admission_result_type r;
      r.kind  = kind;
      r.rid   = rid;
      r.rprio = rprio;
      r.occ   = '0;
      r.wcnt  = '0;
      r.last  = 1'b0;
      return r;
   endfunction

   // Applies one accepted request to the shadow state and queues its results.
   task automatic predict_admission(input logic [OP_W-1:0] op,
                                    input logic [PRIO_W-1:0] prio,
                                    input logic [ID_W-1:0] id);
      admission_result_type step_results[$];
      admission_result_type r;
      awq_entry_type        head;
      int unsigned          pos;
      int unsigned          i;
      case (op)
         OP_ARRIVE: begin
            if (occupancy_shadow < limit_shadow) begin
               occupancy_shadow++;
               step_results.push_back(make_result(KIND_ADMITTED, id, prio));
            end else if (waitlist_count < LIST_DEPTH) begin
               // stable insert: goes behind every entry of equal priority
               pos = 0;
               while (pos < waitlist_count && waitlist_shadow[pos].prio <= prio) pos++;
               for (i = waitlist_count; i > pos; i--) waitlist_shadow[i] = waitlist_shadow[i-1];
               waitlist_shadow[pos].prio = prio;
               waitlist_shadow[pos].id   = id;
               waitlist_count++;
               step_results.push_back(make_result(KIND_QUEUED, id, prio));
            end else begin
               step_results.push_back(make_result(KIND_DROPPED, id, prio));
            end
         end
         OP_DEPART: begin
            if (occupancy_shadow == 0) begin
               step_results.push_back(make_result(KIND_BAD_LEAVE, '0, '0));
            end else begin
               occupancy_shadow--;
               step_results.push_back(make_result(KIND_LEFT, '0, '0));
               // promotion only when exactly the last place was freed
               if (occupancy_shadow + 1 == limit_shadow && waitlist_count > 0) begin
                  head = waitlist_shadow[0];
                  for (i = 1; i < waitlist_count; i++) waitlist_shadow[i-1] = waitlist_shadow[i];
                  waitlist_count--;
                  occupancy_shadow++;
                  step_results.push_back(make_result(KIND_PROMOTED, head.id, head.prio));
               end
            end
         end
         OP_LIST: begin
            if (waitlist_count == 0) begin
               step_results.push_back(make_result(KIND_EMPTY, '0, '0));
            end else begin
               for (i = 0; i < waitlist_count; i++)
                  step_results.push_back(make_result(KIND_LISTED, waitlist_shadow[i].id,
                                                     waitlist_shadow[i].prio));
            end
         end
         default: ;  // unused opcode: no result, no change
      endcase
      // occupancy and count are reported as they stand after the whole request
      for (i = 0; i < step_results.size(); i++) begin
         r      = step_results[i];
         r.occ  = occupancy_shadow[OCC_W-1:0];
         r.wcnt = waitlist_count[WCNT_W-1:0];
         r.last = (i == step_results.size() - 1);
         expected_results.push_back(r);
      end
   endtask

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Offers one request, holds it until taken, then predicts it. Valid is left
   // high so back-to-back requests need no second assignment in one step.
   task automatic send_request(input logic [OP_W-1:0] op,
                               input logic [PRIO_W-1:0] prio,
                               input logic [ID_W-1:0] id);
      int gap;
      gap = 0;
      while (gap < 30 && $urandom_range(99) < req_gap_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, id, prio, op};
      do @(posedge clock); while (!req_tready);
      predict_admission(op, prio, id);
   endtask

   // Random request; arrive_weight is the share of arrivals in percent.
   task automatic send_random_request(input int arrive_weight);
      int                pick;
      logic [OP_W-1:0]   op;
      logic [PRIO_W-1:0] prio;
      pick = $urandom_range(99);
      if (pick < arrive_weight)                               op = OP_ARRIVE;
      else if (pick < arrive_weight + (100-arrive_weight)*2/3) op = OP_DEPART;
      else if (pick < 96)                                      op = OP_LIST;
      else                                                     op = OP_NONE;
      // half of the priorities from a narrow band so ties are common
      if ($urandom_range(1)) prio = 8'($urandom_range(3));
      else                   prio = 8'($urandom);
      send_request(op, prio, 16'($urandom));
   endtask

   // Sender pauses until every predicted result has come back.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Limit is only changed while idle: drain, let the block settle, then write.
   task automatic write_limit(input logic [7:0] value);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      limit_shadow = 32'(value);
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------
   initial begin : result_receiver
      int hold_left;
      int hold_seen;
      rsp_tready = 1'b0;
      hold_left  = 0;
      hold_seen  = 0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_off_requests) begin
            hold_seen = hold_off_requests;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic compare_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         $error("%s expected %0h actual %0h", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : result_checker
      admission_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("result with no request pending: kind %0d tdata %0h", rsp_tuser, rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            compare_field("kind",            16'(want.kind),  16'(rsp_tuser));
            compare_field("result_id",       want.rid,        rsp_tdata[15:0]);
            compare_field("result_priority", 16'(want.rprio), 16'(rsp_tdata[23:16]));
            compare_field("occupancy_now",   16'(want.occ),   16'(rsp_tdata[31:24]));
            compare_field("waiting_count",   16'(want.wcnt),  16'(rsp_tdata[38:32]));
            compare_field("last",            16'(want.last),  16'(rsp_tlast));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Reset limit of 8: empty readout, bad leave, unused opcode, field extremes,
   // stable ordering of ties, promotion on departure.
   task automatic test_reset_defaults();
      int k;
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      send_request(OP_LIST,   8'h00, 16'h0000);
      send_request(OP_DEPART, 8'h00, 16'h0000);   // nobody inside yet
      send_request(OP_NONE,   8'hFF, 16'hFFFF);
      send_request(OP_ARRIVE, 8'hFF, 16'hFFFF);
      send_request(OP_ARRIVE, 8'h00, 16'h0000);
      for (k = 0; k < 6; k++) send_request(OP_ARRIVE, 8'(k), 16'(32'h0100 + k));
      // house is full now; these go to the list
      send_request(OP_ARRIVE, 8'hFF, 16'hA5A5);
      send_request(OP_ARRIVE, 8'h00, 16'h0001);
      send_request(OP_ARRIVE, 8'h00, 16'h0002);   // tie, must stay behind 0001
      send_request(OP_ARRIVE, 8'h80, 16'h5A5A);
      send_request(OP_LIST,   8'h00, 16'h0000);
      send_request(OP_DEPART, 8'h00, 16'h0000);   // left + promoted 0001
      send_request(OP_DEPART, 8'h00, 16'h0000);   // left + promoted 0002
      send_request(OP_LIST,   8'h00, 16'h0000);
   endtask

   // Limit dropped under the current occupancy: departures only count down,
   // promotion comes once occupancy lands on limit - 1.
   task automatic test_limit_below_occupancy();
      int k;
      write_limit(8'd3);
      for (k = 0; k < 6; k++) send_request(OP_DEPART, 8'h00, 16'h0000);
   endtask

   // Receiver holds off for a long stretch while arrivals keep coming, so the
   // output register blocks and the request side stalls; with a limit of zero
   // the list fills up and later arrivals are dropped.
   task automatic test_backpressure_fill();
      int k;
      write_limit(8'd0);
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      hold_off_requests++;
      for (k = 0; k < 40; k++) send_random_request(85);
      wait_for_results();
      for (k = 0; k < 10; k++) send_random_request(45);
   endtask

   task automatic run_random_phase(input logic [7:0] limit_value, input int gap_pct,
                                   input int stall_pct, input int items,
                                   input int arrive_weight);
      int k;
      write_limit(limit_value);
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      for (k = 0; k < items; k++) send_random_request(arrive_weight);
   endtask

   // Several limits, the largest possible one among them, across all idling mixes.
   task automatic test_random_mix();
      run_random_phase(8'd8,   0,  0,  80, 45);
      run_random_phase(8'd1,   61, 0,  70, 50);
      run_random_phase(8'd3,   0,  61, 70, 50);
      run_random_phase(8'd255, 37, 37, 60, 55);
      run_random_phase(8'd2,   37, 37, 80, 50);
   endtask

   initial begin : test_flow
      reset             = 1'b1;
      req_tvalid        = 1'b0;
      req_tdata         = '0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_gap_pct       = 0;
      rsp_stall_pct     = 0;
      hold_off_requests = 0;
      mismatch_count    = 0;
      limit_shadow      = 8;
      occupancy_shadow  = 0;
      waitlist_count    = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_limit_below_occupancy();
      test_backpressure_fill();
      test_random_mix();

      // drain, then watch for stray results a while longer
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d results never arrived", expected_results.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- admission_with_priority_waitlist.f -----
+incdir+hw/rtl
hw/rtl/awq_pkg.sv
hw/rtl/awq_cell.sv
hw/rtl/awq_chain.sv
hw/rtl/admission_with_priority_waitlist.sv
bench/tb_admission_with_priority_waitlist.sv
